FILE: design/ppmfd_pkg.sv
// Shared types and constants for the PPM frame decoder.
// Holds the transaction payload structs, configuration layout and codes.
// No dependencies; every other design file imports this package.
`default_nettype none

package ppmfd_pkg;

	localparam int NUM_CHANNELS_DFLT = 8;
	localparam int TIME_WIDTH_DFLT   = 16;

	localparam int OUT_CHANS = 8;
	localparam int CHAN_W    = 16;
	localparam int SLOT_W    = 4;
	localparam int LOST_W    = 4;
	localparam int STAMP_W   = 16;

	localparam int SYNC_GAP_W = 16;
	localparam int TRIM_W     = 8;
	localparam int LIMIT_W    = 4;
	localparam int PERIOD_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM           = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_PERIOD = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [SYNC_GAP_W-1:0] SYNC_GAP_RST = 16'd4000;
	localparam logic [TRIM_W-1:0]     TRIM_RST     = 8'd2;
	localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 4'd2;
	localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 17'd40001;

	// Event codes carried in the command field.
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic                command;
		logic [STAMP_W-1:0]  edge_time;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan0;
		logic [CHAN_W-1:0] chan1;
		logic [CHAN_W-1:0] chan2;
		logic [CHAN_W-1:0] chan3;
		logic [CHAN_W-1:0] chan4;
		logic [CHAN_W-1:0] chan5;
		logic [CHAN_W-1:0] chan6;
		logic [CHAN_W-1:0] chan7;
		logic              frame_done;
		logic              signal_lost;
		logic              in_frame;
	} out_item_t;

	typedef struct packed {
		logic [SYNC_GAP_W-1:0] sync_gap;
		logic [TRIM_W-1:0]     trim;
		logic [LIMIT_W-1:0]    lost_limit;
		logic [PERIOD_W-1:0]   counter_period;
	} cfg_t;

	typedef struct packed {
		logic frame_done;
		logic signal_lost;
		logic in_frame;
	} status_t;

endpackage

`default_nettype wire

FILE: design/ppm_frame_decoder.sv
// PPM frame decoder top level: configuration registers, handshakes, result register.
// Instantiates ppmfd_gap and ppmfd_core; uses ppmfd_pkg.
//
// Each transaction on the input channel is either a rising edge with its counter
// timestamp or a counter wrap tick, and yields exactly one result carrying the
// eight channel widths, frame completion, failsafe and in-frame flags. An item is
// accepted in every cycle as long as the result register is empty or being drained,
// and its result is presented on the following cycle; throughput is one item per
// clock, set by the single result register. Configuration writes are registered and
// should be made while no result is outstanding.
`default_nettype none

module ppm_frame_decoder
	import ppmfd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DFLT,
	parameter int TIME_WIDTH   = TIME_WIDTH_DFLT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                        cfg_q;
	logic                        accept;
	logic [TIME_WIDTH-1:0]       now;
	logic [TIME_WIDTH-1:0]       prev_time;
	logic                        is_sync;
	logic [CHAN_W-1:0]           chan_val;
	logic [OUT_CHANS-1:0][CHAN_W-1:0] chans_next;
	status_t                     status_next;
	logic                        out_valid_q;
	out_item_t                   out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_gap       <= SYNC_GAP_RST;
			cfg_q.trim           <= TRIM_RST;
			cfg_q.lost_limit     <= LIMIT_RST;
			cfg_q.counter_period <= PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SYNC_GAP:       cfg_q.sync_gap       <= cfg_data[SYNC_GAP_W-1:0];
				REG_TRIM:           cfg_q.trim           <= cfg_data[TRIM_W-1:0];
				REG_LOST_LIMIT:     cfg_q.lost_limit     <= cfg_data[LIMIT_W-1:0];
				REG_COUNTER_PERIOD: cfg_q.counter_period <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign now      = TIME_WIDTH'(in_data.edge_time);

	ppmfd_gap #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_gap (
		.now       (now),
		.prev_time (prev_time),
		.cfg       (cfg_q),
		.is_sync   (is_sync),
		.chan_val  (chan_val)
	);

	ppmfd_core #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (in_data.command),
		.now         (now),
		.is_sync     (is_sync),
		.chan_val    (chan_val),
		.lost_limit  (cfg_q.lost_limit),
		.prev_time   (prev_time),
		.chans_next  (chans_next),
		.status_next (status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.chan0       <= chans_next[0];
			out_q.chan1       <= chans_next[1];
			out_q.chan2       <= chans_next[2];
			out_q.chan3       <= chans_next[3];
			out_q.chan4       <= chans_next[4];
			out_q.chan5       <= chans_next[5];
			out_q.chan6       <= chans_next[6];
			out_q.chan7       <= chans_next[7];
			out_q.frame_done  <= status_next.frame_done;
			out_q.signal_lost <= status_next.signal_lost;
			out_q.in_frame    <= status_next.in_frame;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: design/ppmfd_gap.sv
// Edge gap measurement: modular gap since the previous edge, sync test and trim.
// Purely combinational; depends on ppmfd_pkg.
`default_nettype none

module ppmfd_gap
	import ppmfd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DFLT
) (
	input  wire logic [TIME_WIDTH-1:0] now,
	input  wire logic [TIME_WIDTH-1:0] prev_time,
	input  wire cfg_t                  cfg,
	output logic                       is_sync,
	output logic [CHAN_W-1:0]          chan_val
);

	localparam int GW = (TIME_WIDTH + 1 > PERIOD_W) ? TIME_WIDTH + 1 : PERIOD_W;
	localparam int CW = (TIME_WIDTH > CHAN_W) ? TIME_WIDTH : CHAN_W;

	logic [GW-1:0]         full_period;
	logic [GW-1:0]         period_ext;
	logic [GW-1:0]         eff_period;
	logic [GW-1:0]         wrapped;
	logic [TIME_WIDTH-1:0] gap;
	logic [TIME_WIDTH-1:0] trim_ext;
	logic [TIME_WIDTH-1:0] trimmed;
	logic [CW-1:0]         gap_wide;
	logic [CW-1:0]         trimmed_wide;

	assign full_period = GW'(1) << TIME_WIDTH;
	assign period_ext  = GW'(cfg.counter_period);

	// A zero period, or one beyond the counter range, behaves as the full range.
	assign eff_period = (period_ext == '0 || period_ext > full_period) ? full_period
		: period_ext;

	assign wrapped = eff_period + GW'(now) - GW'(prev_time);

	always_comb begin
		if (now >= prev_time) begin
			gap = now - prev_time;
		end else begin
			gap = wrapped[TIME_WIDTH-1:0];
		end
	end

	assign gap_wide = CW'(gap);
	assign is_sync  = gap_wide > CW'(cfg.sync_gap);

	assign trim_ext     = TIME_WIDTH'(cfg.trim);
	assign trimmed      = (gap > trim_ext) ? gap - trim_ext : '0;
	assign trimmed_wide = CW'(trimmed);
	assign chan_val     = trimmed_wide[CHAN_W-1:0];

endmodule

`default_nettype wire

FILE: design/ppmfd_core.sv
// Decoder state: edge history, frame sequencing, channel store and lost counter.
// Computes the post-transaction state and commits it on acceptance; uses ppmfd_pkg.
`default_nettype none

module ppmfd_core
	import ppmfd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DFLT,
	parameter int TIME_WIDTH   = TIME_WIDTH_DFLT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic                              command,
	input  wire logic [TIME_WIDTH-1:0]             now,
	input  wire logic                              is_sync,
	input  wire logic [CHAN_W-1:0]                 chan_val,
	input  wire logic [LIMIT_W-1:0]                lost_limit,
	output logic [TIME_WIDTH-1:0]                  prev_time,
	output logic [OUT_CHANS-1:0][CHAN_W-1:0]       chans_next,
	output status_t                                status_next
);

	localparam int STORED = (NUM_CHANNELS < OUT_CHANS) ? NUM_CHANNELS : OUT_CHANS;

	logic [TIME_WIDTH-1:0]          prev_q, prev_d;
	logic                           have_q, have_d;
	logic                           sync_q, sync_d;
	logic [SLOT_W-1:0]              slot_q, slot_d;
	logic [STORED-1:0][CHAN_W-1:0]  chan_q, chan_d;
	logic [LOST_W-1:0]              lost_q, lost_d;
	logic [LOST_W-1:0]              lim;
	logic [LOST_W-1:0]              cap;
	logic [LOST_W-1:0]              lost_inc;
	logic                           done;
	logic                           lost;

	assign lim      = (lost_limit == '0) ? LOST_W'(1) : lost_limit;
	assign cap      = (lim == '1) ? lim : lim + LOST_W'(1);
	assign lost_inc = lost_q + LOST_W'(1);

	always_comb begin
		prev_d = prev_q;
		have_d = have_q;
		sync_d = sync_q;
		slot_d = slot_q;
		chan_d = chan_q;
		lost_d = lost_q;
		done   = 1'b0;
		lost   = 1'b0;
		if (command == CMD_EDGE) begin
			prev_d = now;
			if (!have_q) begin
				have_d = 1'b1;
			end else if (!sync_q) begin
				if (is_sync) begin
					sync_d = 1'b1;
					slot_d = '0;
				end
			end else begin
				// Slots beyond the eight visible channels are counted but not kept.
				for (int j = 0; j < STORED; j++) begin
					if (slot_q == SLOT_W'(j)) begin
						chan_d[j] = chan_val;
					end
				end
				if (slot_q == SLOT_W'(NUM_CHANNELS - 1)) begin
					sync_d = 1'b0;
					slot_d = '0;
					lost_d = '0;
					done   = 1'b1;
				end else begin
					slot_d = slot_q + SLOT_W'(1);
				end
			end
		end else begin
			if (lost_q < cap) begin
				lost_d = lost_inc;
				if (lost_inc == lim) begin
					have_d = 1'b0;
					sync_d = 1'b0;
					slot_d = '0;
					chan_d = '0;
					lost   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
			sync_q <= 1'b0;
			slot_q <= '0;
			chan_q <= '0;
			lost_q <= '0;
		end else if (accept) begin
			prev_q <= prev_d;
			have_q <= have_d;
			sync_q <= sync_d;
			slot_q <= slot_d;
			chan_q <= chan_d;
			lost_q <= lost_d;
		end
	end

	assign prev_time = prev_q;

	for (genvar g = 0; g < OUT_CHANS; g++) begin : g_chan_out
		if (g < STORED) begin : g_kept
			assign chans_next[g] = chan_d[g];
		end else begin : g_absent
			assign chans_next[g] = '0;
		end
	end

	assign status_next.frame_done  = done;
	assign status_next.signal_lost = lost;
	assign status_next.in_frame    = sync_d;

endmodule

`default_nettype wire
